/* rtl/lmfh_pkg.sv */
// Shared types and constants for the least-motion frame history median block.
// No dependencies.
package lmfh_pkg;

  localparam int unsigned CntW   = 13;
  localparam int unsigned CntMax = 8191;
  localparam int unsigned KW     = 6;   // holds a sample count up to 63
  localparam int unsigned PixW   = 24;

  localparam logic REG_MEDIAN_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_PLACE,
    ST_QRD,
    ST_QWAIT,
    ST_QFIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic          ins;  // insert data_i into the sorted lists
    logic [KW-1:0] k;    // samples already held
    logic [KW-1:0] n;    // samples the median spans
  } sort_ctrl_t;

endpackage

/* rtl/lmfh_frame_mem.sv */
// Frame store: one write port, one read port with registered read data.
// Depends on lmfh_pkg.
module lmfh_frame_mem import lmfh_pkg::*; #(
  parameter int unsigned Depth = 36864,
  parameter int unsigned AW    = 16
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [PixW-1:0] wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [PixW-1:0] rdata_o
);

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lmfh_sort.sv */
// Per-channel insertion sorter over the samples of one query, with median pick.
// Depends on lmfh_pkg.
module lmfh_sort import lmfh_pkg::*; #(
  parameter int unsigned HistoryDepth = 8
) (
  input  logic            clk_i,
  input  sort_ctrl_t      ctrl_i,
  input  logic [PixW-1:0] data_i,
  output logic [PixW-1:0] median_o
);

  localparam int unsigned RW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [7:0] s_q [HistoryDepth];
    logic [7:0] v;
    logic       lt [HistoryDepth];
    logic [KW-1:0] mid;
    logic [8:0]  sum;

    assign v = data_i[8*c +: 8];

    // lt is monotone over a sorted list; empty entries count as larger
    always_comb begin
      for (int j = 0; j < HistoryDepth; j++) begin
        lt[j] = (KW'(j) >= ctrl_i.k) || (s_q[j] > v);
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.ins) begin
        for (int j = 0; j < HistoryDepth; j++) begin
          if (lt[j]) begin
            if (j > 0 && lt[(j > 0) ? j - 1 : 0]) begin
              s_q[j] <= s_q[(j > 0) ? j - 1 : 0];
            end else begin
              s_q[j] <= v;
            end
          end
        end
      end
    end

    assign mid = ctrl_i.n >> 1;
    assign sum = {1'b0, s_q[RW'(mid - KW'(1))]} + {1'b0, s_q[RW'(mid)]};
    assign median_o[8*c +: 8] = ctrl_i.n[0] ? s_q[RW'(mid)] : sum[8:1];
  end

endmodule

/* rtl/least_motion_frame_history_median_top.sv */
// Top level: control, rank table and APB register of the frame history median.
// Depends on lmfh_pkg, lmfh_frame_mem and lmfh_sort.
//
// Keeps up to HISTORY_DEPTH RGB frames ranked by foreground pixel count,
// fewest first. A frame pixel without last_pixel does not stall the input.
// The last pixel of a frame scans the rank table one entry per cycle,
// stopping at the first entry whose count is greater or equal, and then
// places the frame. A median query reads one sample from each of the first
// n ranked frames from the single-read-port frame memory, n being
// median_count bounded by fill and depth, and sorts each as it arrives; when
// the history is empty or the index is outside the frame, no sample is read.
// Results wait in an output register; frame contents are undefined until
// streamed in.
module least_motion_frame_history_median_top import lmfh_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned FRAME_PIXELS  = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [11:0] pixel_index_i,
  input  logic        foreground_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [3:0]  rank_o,
  output logic        dropped_o,
  output logic [3:0]  fill_level_o,
  output logic [7:0]  red_median_o,
  output logic [7:0]  green_median_o,
  output logic [7:0]  blue_median_o,
  output logic        no_history_o
);

  localparam int unsigned Slots = HISTORY_DEPTH + 1;
  localparam int unsigned SW    = $clog2(Slots);
  localparam int unsigned NW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned RW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned Depth = Slots * FRAME_PIXELS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  state_e state_q, state_d;

  logic [3:0]      mc_q;
  logic [NW-1:0]   fill_q, fill_d;
  logic [SW-1:0]   spare_q, spare_d;
  logic [CntW-1:0] rc_q, rc_d, cnt_q, cnt_d;
  logic [SW-1:0]   ro_q [HISTORY_DEPTH];
  logic [SW-1:0]   ro_d [HISTORY_DEPTH];
  logic [CntW-1:0] rcnt_q [HISTORY_DEPTH];
  logic [CntW-1:0] rcnt_d [HISTORY_DEPTH];
  logic [NW-1:0]   i_q, i_d, pos_q, pos_d, n_q, n_d, k_q, k_d;
  logic            found_q, found_d, rd_v_q, rd_v_d;
  logic [11:0]     pix_q, pix_d;

  // staged result
  logic            r_kind_q, r_kind_d, r_drop_q, r_drop_d, r_nohist_q, r_nohist_d;
  logic [3:0]      r_rank_q, r_rank_d, r_fill_q, r_fill_d;
  logic [PixW-1:0] r_med_q, r_med_d;

  // output register
  logic            o_valid_q, o_valid_d;
  logic            o_kind_q, o_drop_q, o_nohist_q;
  logic [3:0]      o_rank_q, o_fill_q;
  logic [PixW-1:0] o_med_q;
  logic            o_load;

  logic            in_acc, in_range, mem_we;
  logic [AW-1:0]   waddr, raddr;
  logic [PixW-1:0] rdata, median;
  sort_ctrl_t      sctrl;
  logic [NW:0]     n_eff;
  logic            full;
  logic [NW-1:0]   p, lim;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q <= 4'd8;
    end else if (psel && penable && pwrite && paddr[2] == REG_MEDIAN_COUNT) begin
      mc_q <= pwdata[3:0];
    end
  end
  assign prdata = (paddr[2] == REG_MEDIAN_COUNT) ? {28'd0, mc_q} : 32'd0;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = 32'(pixel_index_i) < FRAME_PIXELS;
  assign mem_we     = in_acc && !mode_i && in_range;
  assign waddr      = AW'(32'(spare_q) * FRAME_PIXELS + 32'(pixel_index_i));
  assign raddr      = AW'(32'(ro_q[RW'(i_q)]) * FRAME_PIXELS + 32'(pix_q));

  lmfh_frame_mem #(.Depth(Depth), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sctrl.ins = rd_v_q;
  assign sctrl.k   = KW'(k_q);
  assign sctrl.n   = KW'(n_q);

  lmfh_sort #(.HistoryDepth(HISTORY_DEPTH)) u_sort (
    .clk_i    (clk_i),
    .ctrl_i   (sctrl),
    .data_i   (rdata),
    .median_o (median)
  );

  // samples used: median_count, zero read as one, bounded by fill and depth
  always_comb begin
    n_eff = (mc_q == 4'd0) ? (NW+1)'(1) : (NW+1)'(mc_q);
    if (32'(mc_q) > HISTORY_DEPTH) n_eff = (NW+1)'(HISTORY_DEPTH);
    if (n_eff > {1'b0, fill_q}) n_eff = {1'b0, fill_q};
  end

  assign full = (32'(fill_q) == HISTORY_DEPTH);
  assign p    = found_q ? pos_q : fill_q;
  assign lim  = full ? NW'(HISTORY_DEPTH - 1) : fill_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    spare_d    = spare_q;
    rc_d       = rc_q;
    cnt_d      = cnt_q;
    ro_d       = ro_q;
    rcnt_d     = rcnt_q;
    i_d        = i_q;
    pos_d      = pos_q;
    n_d        = n_q;
    k_d        = k_q + NW'(rd_v_q);
    found_d    = found_q;
    rd_v_d     = 1'b0;
    pix_d      = pix_q;
    r_kind_d   = r_kind_q;
    r_drop_d   = r_drop_q;
    r_nohist_d = r_nohist_q;
    r_rank_d   = r_rank_q;
    r_fill_d   = r_fill_q;
    r_med_d    = r_med_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pix_d = pixel_index_i;
          if (!mode_i) begin
            if (foreground_i && 32'(rc_q) < CntMax) rc_d = rc_q + CntW'(1);
            if (last_pixel_i) begin
              cnt_d   = rc_d;
              rc_d    = '0;
              i_d     = '0;
              found_d = 1'b0;
              state_d = ST_SRCH;
            end
          end else begin
            r_kind_d   = 1'b1;
            r_rank_d   = '0;
            r_drop_d   = 1'b0;
            r_fill_d   = 4'(fill_q);
            r_med_d    = '0;
            r_nohist_d = (fill_q == '0);
            if (fill_q == '0 || !in_range) begin
              state_d = ST_OUT;
            end else begin
              n_d     = NW'(n_eff);
              i_d     = '0;
              k_d     = '0;
              state_d = ST_QRD;
            end
          end
        end
      end
      ST_SRCH: begin
        if (i_q < fill_q) begin
          if (cnt_q <= rcnt_q[RW'(i_q)]) begin
            found_d = 1'b1;
            pos_d   = i_q;
            state_d = ST_PLACE;
          end else begin
            i_d = i_q + NW'(1);
          end
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        r_kind_d   = 1'b0;
        r_nohist_d = 1'b0;
        r_med_d    = '0;
        if (found_q || !full) begin
          for (int j = 0; j < HISTORY_DEPTH; j++) begin
            if (NW'(j) == p) begin
              ro_d[j]   = spare_q;
              rcnt_d[j] = cnt_q;
            end else if (NW'(j) > p && NW'(j) <= lim && j > 0) begin
              ro_d[j]   = ro_q[(j > 0) ? j - 1 : 0];
              rcnt_d[j] = rcnt_q[(j > 0) ? j - 1 : 0];
            end
          end
          if (full) begin
            spare_d = ro_q[HISTORY_DEPTH-1];
          end else begin
            fill_d  = fill_q + NW'(1);
            spare_d = SW'(fill_d);
          end
          r_rank_d = 4'(p);
          r_drop_d = 1'b0;
        end else begin
          r_rank_d = 4'(HISTORY_DEPTH);
          r_drop_d = 1'b1;
        end
        r_fill_d = 4'(fill_d);
        state_d  = ST_OUT;
      end
      ST_QRD: begin
        rd_v_d = 1'b1;
        i_d    = i_q + NW'(1);
        if (i_q == n_q - NW'(1)) state_d = ST_QWAIT;
      end
      ST_QWAIT: begin
        state_d = ST_QFIN;
      end
      ST_QFIN: begin
        r_med_d = median;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (o_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign o_load = (state_q == ST_OUT) && (!o_valid_q || !out_stall_i);

  always_comb begin
    o_valid_d = o_valid_q;
    if (o_load) begin
      o_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      spare_q   <= '0;
      rc_q      <= '0;
      i_q       <= '0;
      k_q       <= '0;
      rd_v_q    <= 1'b0;
      o_valid_q <= 1'b0;
      for (int j = 0; j < HISTORY_DEPTH; j++) ro_q[j] <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      spare_q   <= spare_d;
      rc_q      <= rc_d;
      i_q       <= i_d;
      k_q       <= k_d;
      rd_v_q    <= rd_v_d;
      o_valid_q <= o_valid_d;
      ro_q      <= ro_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    rcnt_q     <= rcnt_d;
    pos_q      <= pos_d;
    n_q        <= n_d;
    found_q    <= found_d;
    pix_q      <= pix_d;
    r_kind_q   <= r_kind_d;
    r_drop_q   <= r_drop_d;
    r_nohist_q <= r_nohist_d;
    r_rank_q   <= r_rank_d;
    r_fill_q   <= r_fill_d;
    r_med_q    <= r_med_d;
    if (o_load) begin
      o_kind_q   <= r_kind_q;
      o_drop_q   <= r_drop_q;
      o_nohist_q <= r_nohist_q;
      o_rank_q   <= r_rank_q;
      o_fill_q   <= r_fill_q;
      o_med_q    <= r_med_q;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign kind_o         = o_kind_q;
  assign rank_o         = o_rank_q;
  assign dropped_o      = o_drop_q;
  assign fill_level_o   = o_fill_q;
  assign red_median_o   = o_med_q[23:16];
  assign green_median_o = o_med_q[15:8];
  assign blue_median_o  = o_med_q[7:0];
  assign no_history_o   = o_nohist_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= HISTORY_DEPTH)
    else $error("history fill beyond depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o && dropped_o |-> 32'(fill_level_o) == HISTORY_DEPTH)
    else $error("frame dropped while history not full");

  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QFIN |-> k_q == n_q)
    else $error("median formed over wrong number of samples");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode_i || last_pixel_i) |=> in_stall_o)
    else $error("item accepted while result in progress");

endmodule
